// ----- design/srd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srd_pkg: shared types and constants of the serial report deframer
// Frame layout positions, result kinds and the result record.
// ----------------------------------------------------------------------------
package srd_pkg;

  // Frame buffer size in bytes; a frame or line reaching this size is cut off
  localparam int unsigned BUF_BYTES = 1024;
  localparam int unsigned POS_W     = $clog2(BUF_BYTES);
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned END_W     = LEN_W + 1;

  localparam logic [7:0] START_MARK = 8'hFE;
  localparam logic [7:0] NEWLINE    = 8'h0A;

  // Byte positions within a frame
  localparam logic [POS_W-1:0] POS_LEN_LO   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LEN_HI   = POS_W'(2);
  localparam logic [POS_W-1:0] POS_MSG_TYPE = POS_W'(3);
  localparam logic [POS_W-1:0] POS_DEV_TYPE = POS_W'(4);
  localparam logic [POS_W-1:0] POS_DEVICE   = POS_W'(5);
  localparam logic [POS_W-1:0] POS_ENDPOINT = POS_W'(6);
  localparam logic [POS_W-1:0] POS_VEND_LO  = POS_W'(7);
  localparam logic [POS_W-1:0] POS_VEND_HI  = POS_W'(8);
  localparam logic [POS_W-1:0] POS_PROD_LO  = POS_W'(9);
  localparam logic [POS_W-1:0] POS_PROD_HI  = POS_W'(10);
  localparam logic [POS_W-1:0] POS_HDR_END  = POS_W'(11);
  localparam logic [POS_W-1:0] POS_LAST     = POS_W'(BUF_BYTES - 1);

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_DISCARD  = 2'd2,
    KIND_OVERFLOW = 2'd3
  } srd_kind_e;

  typedef struct packed {
    srd_kind_e          kind;
    logic [7:0]         msg_type;
    logic [7:0]         dev_type;
    logic [7:0]         device_port;
    logic [7:0]         endpoint_num;
    logic [15:0]        vendor_id;
    logic [15:0]        product_id;
    logic [LEN_W-1:0]   payload_length;
    logic [7:0]         data_byte;
    logic [COUNT_W-1:0] byte_count;
    logic               last;
  } srd_result_t;

endpackage
`default_nettype wire

// ----- design/srd_rx_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srd_rx_if: received byte channel
// Valid/ready channel carrying one serial byte per transaction.
// ----------------------------------------------------------------------------
interface srd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ----- design/srd_res_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srd_res_if: deframer result channel
// Valid/ready channel carrying one result record per transaction.
// ----------------------------------------------------------------------------
interface srd_res_if;
  import srd_pkg::*;
  logic        valid;
  logic        ready;
  srd_result_t result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface
`default_nettype wire

// ----- design/srd_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srd_parser: frame state and per-byte decode
// Holds position, frame flag and header registers; decodes each accepted
// byte into at most one result in the same cycle.
// ----------------------------------------------------------------------------
module srd_parser
  import srd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [7:0]  rx_byte_i,
  output      logic        res_valid_o,
  output      srd_result_t res_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic             in_frame_q, in_frame_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [7:0]       msg_type_q, msg_type_d;
  logic [7:0]       dev_type_q, dev_type_d;
  logic [7:0]       device_q, device_d;
  logic [7:0]       endpoint_q, endpoint_d;
  logic [15:0]      vendor_q, vendor_d;
  logic [15:0]      product_q, product_d;

  logic [POS_W:0]   pos_inc;
  logic [END_W-1:0] frame_end;
  logic [END_W-1:0] pos_ext;
  logic             in_body;

  assign pos_inc   = {1'b0, pos_q} + (POS_W + 1)'(1);
  assign frame_end = {1'b0, len_q} + END_W'(POS_HDR_END);
  assign pos_ext   = END_W'(pos_q);
  assign in_body   = pos_q >= POS_HDR_END;

  always_comb begin
    pos_d       = pos_q;
    in_frame_d  = in_frame_q;
    len_d       = len_q;
    msg_type_d  = msg_type_q;
    dev_type_d  = dev_type_q;
    device_d    = device_q;
    endpoint_d  = endpoint_q;
    vendor_d    = vendor_q;
    product_d   = product_q;
    res_valid_o = 1'b0;

    res_o                = '0;
    res_o.kind           = KIND_PAYLOAD;
    res_o.byte_count     = COUNT_W'(pos_inc);
    res_o.msg_type       = msg_type_q;
    res_o.dev_type       = dev_type_q;
    res_o.device_port    = device_q;
    res_o.endpoint_num   = endpoint_q;
    res_o.vendor_id      = vendor_q;
    res_o.product_id     = product_q;
    res_o.payload_length = len_q;

    if (!in_frame_q) begin
      // Unframed results carry no header
      res_o.msg_type       = '0;
      res_o.dev_type       = '0;
      res_o.device_port    = '0;
      res_o.endpoint_num   = '0;
      res_o.vendor_id      = '0;
      res_o.product_id     = '0;
      res_o.payload_length = '0;
      if (pos_q == '0 && rx_byte_i == START_MARK) begin
        in_frame_d = 1'b1;
        len_d      = '0;
        msg_type_d = '0;
        dev_type_d = '0;
        device_d   = '0;
        endpoint_d = '0;
        vendor_d   = '0;
        product_d  = '0;
        pos_d      = POS_W'(1);
      end else if (rx_byte_i == NEWLINE) begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_DISCARD;
        pos_d       = '0;
      end else if (pos_q == POS_LAST) begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_OVERFLOW;
        pos_d       = '0;
      end else begin
        pos_d = POS_W'(pos_inc);
      end
    end else begin
      case (pos_q)
        POS_LEN_LO:   len_d = {8'h00, rx_byte_i};
        POS_LEN_HI:   len_d = {rx_byte_i, len_q[7:0]};
        POS_MSG_TYPE: msg_type_d = rx_byte_i;
        POS_DEV_TYPE: dev_type_d = rx_byte_i;
        POS_DEVICE:   device_d = rx_byte_i;
        POS_ENDPOINT: endpoint_d = rx_byte_i;
        POS_VEND_LO:  vendor_d = {8'h00, rx_byte_i};
        POS_VEND_HI:  vendor_d = {rx_byte_i, vendor_q[7:0]};
        POS_PROD_LO:  product_d = {8'h00, rx_byte_i};
        POS_PROD_HI:  product_d = {rx_byte_i, product_q[7:0]};
        default:      ;
      endcase

      // Header registers are stable once the body starts
      if (in_body && pos_ext == frame_end) begin
        res_valid_o     = 1'b1;
        res_o.kind      = KIND_DONE;
        res_o.data_byte = rx_byte_i;
        in_frame_d      = 1'b0;
        pos_d           = '0;
      end else if (pos_q == POS_LAST) begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_OVERFLOW;
        in_frame_d  = 1'b0;
        pos_d       = '0;
      end else begin
        pos_d = POS_W'(pos_inc);
        if (in_body && pos_ext < frame_end) begin
          res_valid_o     = 1'b1;
          res_o.kind      = KIND_PAYLOAD;
          res_o.data_byte = rx_byte_i;
          res_o.last      = END_W'(pos_inc) == frame_end;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      in_frame_q <= 1'b0;
      len_q      <= '0;
      msg_type_q <= '0;
      dev_type_q <= '0;
      device_q   <= '0;
      endpoint_q <= '0;
      vendor_q   <= '0;
      product_q  <= '0;
    end else if (accept_i) begin
      pos_q      <= pos_d;
      in_frame_q <= in_frame_d;
      len_q      <= len_d;
      msg_type_q <= msg_type_d;
      dev_type_q <= dev_type_d;
      device_q   <= device_d;
      endpoint_q <= endpoint_d;
      vendor_q   <= vendor_d;
      product_q  <= product_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/srd_out_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srd_out_reg: result register
// Holds one result until the receiver takes it; frees itself in the cycle
// the held result is taken, so a new byte can enter every cycle while held results are taken.
// ----------------------------------------------------------------------------
module srd_out_reg
  import srd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire logic        res_valid_i,
  input  wire srd_result_t res_i,
  output      logic        in_ready_o,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      srd_result_t out_o
);

  logic        valid_q;
  srd_result_t data_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= load_i && res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && load_i && res_valid_i) begin
      data_q <= res_i;
    end
  end

endmodule
`default_nettype wire

// ----- design/serial_report_deframer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// serial_report_deframer: deframer for length-prefixed serial reports
// Takes received serial bytes on rx_i and gives decoded results on res_o.
// A frame opens with 0xFE at line start, then a little-endian 16-bit payload
// length, an 8-byte header, the payload and one trailer byte. Each payload
// byte leaves as a payload result with the header attached; the trailer
// leaves as a frame-complete result. Unframed bytes up to a newline give
// one discard result with the count; a frame or line reaching the buffer
// size gives an overflow result and the parser returns to line start.
// A result is registered and valid on res_o in the cycle after its byte's transaction.
// Throughput: one byte per cycle while results are taken as they appear.
// The parser state and one result register set the rate: rx_i stays ready
// while the result register is empty or being taken in the same cycle.
// When the receiver stalls, the held result stays put and rx_i drops ready
// for every byte, with or without a result, until the held one is taken.
// Reset clears the position, the frame flag and the header registers, and
// empties the result register.
// ----------------------------------------------------------------------------
module serial_report_deframer
  import srd_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  srd_rx_if.sink   rx_i,
  srd_res_if.source res_o
);

  logic        accept;
  logic        in_ready;
  logic        res_valid;
  srd_result_t res;

  assign rx_i.ready = in_ready;
  assign accept     = rx_i.valid && in_ready;

  srd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_i.rx_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  srd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_valid_i (res_valid),
    .res_i       (res),
    .in_ready_o  (in_ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_o       (res_o.result)
  );

endmodule
`default_nettype wire
